FILE: rtl/olid_pkg.sv
package olid_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned INDEX_W      = 6;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 2'd2;

    // controller -> datapath, valid for the current cycle only
    typedef struct packed {
        logic ins_front;   // write value before head, grow
        logic ins_back;    // write value after tail, grow
        logic del_front;   // drop the head entry
        logic count_dec;   // shrink after a gap close
        logic shift_wr;    // write read data at wr_log
        logic rd_en;       // read entry at rd_log
        logic emit;        // read goes to the result stage
        logic emit_last;
        logic emit_empty;
        logic emit_drop;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rd_busy;     // result stage holds an item not yet moved out
        logic slot_free;   // result stage can take a new item this cycle
    } t_stat;

endpackage

FILE: rtl/olid_dp.sv
module olid_dp
    import olid_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [CW-1:0]             i_rd_log,
    input  logic [CW-1:0]             i_wr_log,
    input  logic signed [VALUE_W-1:0] i_value,
    output t_stat                     o_stat,
    output logic [CW-1:0]             o_count,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_item_value,
    output logic                      o_is_last,
    output logic                      o_list_empty,
    output logic                      o_insert_dropped
);

    localparam int unsigned SW = CW + 1;

    // circular storage: logical position p lives at (head + p) mod CAPACITY
    logic [VALUE_W-1:0] r_mem [CAPACITY];

    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [VALUE_W-1:0] r_rd_q;
    logic               r_rd_pend, n_rd_pend;
    logic               r_rd_last, r_rd_empty, r_rd_drop;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last, r_out_empty, r_out_drop;

    logic               move;
    logic [AW-1:0]      head_m1, head_p1;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign head_m1 = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign head_p1 = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
    assign rd_addr = f_phys(r_head, i_rd_log);

    assign move      = r_rd_pend && (!r_out_valid || i_ready);
    assign n_rd_pend = i_cmd.emit ? 1'b1 : (move ? 1'b0 : r_rd_pend);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = i_value;
        n_head  = r_head;
        n_count = r_count;
        priority if (i_cmd.ins_front) begin
            wr_en   = 1'b1;
            wr_addr = head_m1;
            n_head  = head_m1;
            n_count = r_count + CW'(1);
        end else if (i_cmd.ins_back) begin
            wr_en   = 1'b1;
            wr_addr = f_phys(r_head, r_count);
            n_count = r_count + CW'(1);
        end else begin
            if (i_cmd.shift_wr) begin
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, i_wr_log);
                wr_data = r_rd_q;
            end
            if (i_cmd.del_front) begin
                n_head  = head_p1;
                n_count = r_count - CW'(1);
            end
            if (i_cmd.count_dec) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_rd_pend <= n_rd_pend;
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rd_last  <= i_cmd.emit_last;
            r_rd_empty <= i_cmd.emit_empty;
            r_rd_drop  <= i_cmd.emit_drop;
        end
        if (move) begin
            r_out_value <= r_rd_empty ? '0 : r_rd_q;
            r_out_last  <= r_rd_last;
            r_out_empty <= r_rd_empty;
            r_out_drop  <= r_rd_drop;
        end
    end

    assign o_stat.rd_busy   = r_rd_pend;
    assign o_stat.slot_free = !r_rd_pend || move;
    assign o_count          = r_count;

    assign o_valid          = r_out_valid;
    assign o_item_value     = r_out_value;
    assign o_is_last        = r_out_last;
    assign o_list_empty     = r_out_empty;
    assign o_insert_dropped = r_out_drop;

endmodule

FILE: rtl/olid_ctrl.sv
module olid_ctrl
    import olid_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [INDEX_W-1:0] i_index,
    input  t_stat              i_stat,
    input  logic [CW-1:0]      i_count,
    output t_cmd               o_cmd,
    output logic [CW-1:0]      o_rd_log,
    output logic [CW-1:0]      o_wr_log
);

    localparam int unsigned CMPW = (INDEX_W > CW) ? INDEX_W : CW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DEL  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_prim, n_prim;   // a gap-close read is in flight
    logic          r_drop, n_drop;

    logic          full;
    logic          in_range;
    logic [CW-1:0] j;
    logic          last;

    assign full     = (i_count == CW'(CAPACITY));
    assign in_range = (CMPW'(i_index) < CMPW'(i_count));
    assign j        = r_prim ? r_idx + CW'(1) : r_idx;
    assign last     = ((r_idx + CW'(1)) == i_count);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_prim   = r_prim;
        n_drop   = r_drop;
        o_cmd    = '0;
        o_rd_log = '0;
        o_wr_log = '0;
        o_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_idx   = '0;
                    n_prim  = 1'b0;
                    n_drop  = 1'b0;
                    n_state = ST_EMIT;
                    if (i_mode == MODE_INS_FRONT || i_mode == MODE_INS_BACK) begin
                        priority if (full) begin
                            n_drop = 1'b1;
                        end else if (i_mode == MODE_INS_FRONT) begin
                            o_cmd.ins_front = 1'b1;
                        end else begin
                            o_cmd.ins_back = 1'b1;
                        end
                    end else if (i_mode == MODE_DELETE && in_range) begin
                        if (i_index == '0) begin
                            o_cmd.del_front = 1'b1;
                        end else begin
                            n_idx   = CW'(i_index);
                            n_state = ST_DEL;
                        end
                    end
                end
            end
            ST_DEL: begin
                // read entry j+1, write it at j in the next cycle; reuses the
                // read register, so start only once the result stage is clear
                if (r_prim || !i_stat.rd_busy) begin
                    o_cmd.shift_wr = r_prim;
                    o_wr_log       = r_idx;
                    if ((j + CW'(1)) < i_count) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_log    = j + CW'(1);
                        n_prim      = 1'b1;
                        n_idx       = j;
                    end else begin
                        o_cmd.count_dec = 1'b1;
                        n_prim          = 1'b0;
                        n_idx           = '0;
                        n_state         = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_drop = r_drop;
                    if (i_count == '0) begin
                        o_cmd.emit_empty = 1'b1;
                        o_cmd.emit_last  = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        o_cmd.rd_en     = 1'b1;
                        o_rd_log        = r_idx;
                        o_cmd.emit_last = last;
                        n_idx           = r_idx + CW'(1);
                        if (last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_prim  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_prim  <= n_prim;
            r_drop  <= n_drop;
        end
    end

endmodule

FILE: rtl/ordered_list_insert_delete.sv
// Bounded ordered list of up to CAPACITY signed 32-bit entries, kept in a
// circular buffer memory so that inserts at either end take no shifting.
// An operation is taken while the block is idle, then the list is streamed out front to
// back, one result per cycle while the consumer keeps ready high, with the
// final result marked (an empty list gives one result flagged empty). Inserts
// and no-ops, and a delete at the front, go straight to the listing; a
// delete at position p > 0 first closes the gap through the memory's single
// read and write port, and waits for the previous operation's last result to
// leave the read register. The next item is taken as soon as the last read of
// the current list has been issued; results of the previous operation may
// still be draining from the output register.
module ordered_list_insert_delete
    import olid_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [INDEX_W-1:0]        i_index,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_item_value,
    output logic                      o_is_last,
    output logic                      o_list_empty,
    output logic                      o_insert_dropped
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] count;
    logic [CW-1:0] rd_log;
    logic [CW-1:0] wr_log;
    logic          accept;

    assign accept = i_valid && o_ready;

    olid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_index  (i_index),
        .i_stat   (stat),
        .i_count  (count),
        .o_cmd    (cmd),
        .o_rd_log (rd_log),
        .o_wr_log (wr_log)
    );

    olid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_log         (rd_log),
        .i_wr_log         (wr_log),
        .i_value          (accept ? i_value : '0),
        .o_stat           (stat),
        .o_count          (count),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_item_value     (o_item_value),
        .o_is_last        (o_is_last),
        .o_list_empty     (o_list_empty),
        .o_insert_dropped (o_insert_dropped)
    );

endmodule

FILE: sim/ordered_list_insert_delete_tb.sv
`timescale 1ns / 100ps

module ordered_list_insert_delete_tb;
    import olid_pkg::*;

    localparam int unsigned       LIST_CAP     = CAPACITY_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int                CLK_PERIOD   = 20;
    localparam int                DIR_ROWS     = 26;
    localparam int                RANDOM_ITEMS = 145;
    localparam int                HOLD_CYCLES  = 150;
    // a full listing plus a worst-case gap close
    localparam int                TAIL_CYCLES  = 2 * LIST_CAP + 8;
    localparam int                MAX_REPORTS  = 10;
    localparam int                TIMEOUT_NS   = 4_000_000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      empty;
        logic                      dropped;
    } t_list_item;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
        logic                      typed;
        t_list_item                want;
    } t_dir_row;

    typedef enum int {RDY_STEADY, RDY_COIN, RDY_SPARSE, RDY_MOSTLY, RDY_HOLD} t_ready_kind;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [MODE_W-1:0]         i_mode;
    logic signed [VALUE_W-1:0] i_value;
    logic [INDEX_W-1:0]        i_index;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [VALUE_W-1:0] o_item_value;
    logic                      o_is_last;
    logic                      o_list_empty;
    logic                      o_insert_dropped;

    // list contents as the block should hold them
    logic signed [VALUE_W-1:0] list_model [LIST_CAP];
    int unsigned               model_count;
    t_list_item                listing_q [$];
    int                        err_cnt;
    int                        burst_left;
    bit                        hold_now;
    logic                      drv_typed;
    t_list_item                drv_want;

    t_dir_row dir_table [DIR_ROWS] = '{
        '{MODE_DELETE,    32'sh8000_0000, 6'd0,  1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_UNUSED,    32'sh7FFF_FFFF, 6'd63, 1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_INS_FRONT, 32'sh7FFF_FFFF, 6'd63, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
        '{MODE_DELETE,    32'sd0,         6'd0,  1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_INS_BACK,  32'sh8000_0000, 6'd0,  1'b1, '{32'sh8000_0000, 1'b1, 1'b0, 1'b0}},
        // fill to capacity
        '{MODE_INS_FRONT, 32'sd0,         6'd5,  1'b0, '0},
        '{MODE_INS_BACK,  -32'sd1,        6'd63, 1'b0, '0},
        '{MODE_INS_FRONT, 32'sd1,         6'd0,  1'b0, '0},
        '{MODE_INS_BACK,  32'sh5555_5555, 6'd42, 1'b0, '0},
        '{MODE_INS_FRONT, 32'shAAAA_AAAA, 6'd21, 1'b0, '0},
        '{MODE_INS_BACK,  32'sd2,         6'd1,  1'b0, '0},
        '{MODE_INS_FRONT, -32'sd2,        6'd2,  1'b0, '0},
        '{MODE_INS_BACK,  32'sd100,       6'd3,  1'b0, '0},
        '{MODE_INS_FRONT, -32'sd100,      6'd4,  1'b0, '0},
        '{MODE_INS_BACK,  32'sh1234_5678, 6'd8,  1'b0, '0},
        '{MODE_INS_FRONT, 32'shFEDC_BA98, 6'd16, 1'b0, '0},
        '{MODE_INS_BACK,  32'sd3,         6'd32, 1'b0, '0},
        '{MODE_INS_FRONT, 32'sh7FFF_FFFF, 6'd15, 1'b0, '0},
        '{MODE_INS_BACK,  32'sh8000_0000, 6'd30, 1'b0, '0},
        '{MODE_INS_FRONT, 32'sd42,        6'd60, 1'b0, '0},
        // full list: inserts refused, delete exactly at count
        '{MODE_INS_FRONT, 32'sd99,        6'd0,  1'b0, '0},
        '{MODE_INS_BACK,  -32'sd99,       6'd0,  1'b0, '0},
        '{MODE_DELETE,    32'sd7,         6'd16, 1'b0, '0},
        '{MODE_DELETE,    32'sd0,         6'd15, 1'b0, '0},
        '{MODE_DELETE,    32'sh7FFF_FFFF, 6'd0,  1'b0, '0},
        '{MODE_DELETE,    -32'sd1,        6'd7,  1'b0, '0}
    };

    ordered_list_insert_delete dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_value          (i_value),
        .i_index          (i_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_item_value     (o_item_value),
        .o_is_last        (o_is_last),
        .o_list_empty     (o_list_empty),
        .o_insert_dropped (o_insert_dropped)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // update the list and queue the listing that follows the operation
    task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                                 input logic signed [VALUE_W-1:0] value,
                                 input logic [INDEX_W-1:0] index);
        logic       dropped;
        t_list_item res;
        int         i;
        dropped = 1'b0;
        if (mode == MODE_INS_FRONT || mode == MODE_INS_BACK) begin
            if (model_count == LIST_CAP) begin
                dropped = 1'b1;
            end else if (mode == MODE_INS_FRONT) begin
                for (i = model_count; i > 0; i--) list_model[i] = list_model[i - 1];
                list_model[0] = value;
                model_count++;
            end else begin
                list_model[model_count] = value;
                model_count++;
            end
        end else if (mode == MODE_DELETE && index < model_count) begin
            for (i = int'(index); i + 1 < model_count; i++) list_model[i] = list_model[i + 1];
            model_count--;
        end
        if (model_count == 0) begin
            res.value   = '0;
            res.last    = 1'b1;
            res.empty   = 1'b1;
            res.dropped = dropped;
            listing_q.push_back(res);
        end else begin
            for (i = 0; i < model_count; i++) begin
                res.value   = list_model[i];
                res.last    = (i + 1 == model_count);
                res.empty   = 1'b0;
                res.dropped = dropped;
                listing_q.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        int         first;
        t_list_item want;
        if (i_rst_n && $isunknown({o_valid, o_ready})) begin
            flag_error("handshake output unknown after reset");
        end
        if (i_rst_n && i_valid && o_ready) begin
            first = listing_q.size();
            apply_list_op(i_mode, i_value, i_index);
            if (drv_typed) listing_q[first] = drv_want;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (listing_q.size() == 0) begin
                flag_error($sformatf("unexpected result value=%0d last=%b empty=%b drop=%b",
                    o_item_value, o_is_last, o_list_empty, o_insert_dropped));
            end else begin
                want = listing_q.pop_front();
                if (o_item_value !== want.value || o_is_last !== want.last ||
                    o_list_empty !== want.empty || o_insert_dropped !== want.dropped) begin
                    flag_error($sformatf({"mismatch: exp value=%0d last=%b empty=%b drop=%b",
                        " got value=%0d last=%b empty=%b drop=%b"},
                        want.value, want.last, want.empty, want.dropped,
                        o_item_value, o_is_last, o_list_empty, o_insert_dropped));
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_item(input logic [MODE_W-1:0] mode,
                              input logic signed [VALUE_W-1:0] value,
                              input logic [INDEX_W-1:0] index,
                              input logic typed,
                              input t_list_item want);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_value   <= value;
        i_index   <= index;
        drv_typed <= typed;
        drv_want  <= want;
        burst_left--;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic offer_random();
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
        int                        roll;
        int                        ins_pct;
        ins_pct = (model_count + 3 >= LIST_CAP) ? 35 : 65;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) mode = roll[0] ? MODE_INS_BACK : MODE_INS_FRONT;
        else if (roll < 95) mode = MODE_DELETE;
        else mode = MODE_UNUSED;
        case ($urandom_range(0, 7))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
        endcase
        if (mode == MODE_DELETE && model_count > 0 && $urandom_range(0, 3) != 0) begin
            index = INDEX_W'($urandom_range(0, model_count - 1));
        end else begin
            index = INDEX_W'($urandom_range(0, 63));
        end
        offer_item(mode, value, index, 1'b0, '0);
    endtask

    // stop offering until every queued result has come out
    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (listing_q.size() != 0);
        burst_left = $urandom_range(1, 8);
    endtask

    initial begin
        int r;
        int n;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_INS_FRONT;
        i_value     = '0;
        i_index     = '0;
        drv_typed   = 1'b0;
        drv_want    = '0;
        err_cnt     = 0;
        model_count = 0;
        burst_left  = 0;
        hold_now    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (r = 0; r < DIR_ROWS; r++) begin
            offer_item(dir_table[r].mode, dir_table[r].value, dir_table[r].index,
                       dir_table[r].typed, dir_table[r].want);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 30) hold_now = 1'b1;
            if (n == 80) drain_pause();
            offer_random();
        end
        drain_pause();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: stretches of different stall patterns, one long hold-off
    initial begin
        t_ready_kind kind;
        int          run_len;
        i_ready = 1'b0;
        forever begin
            kind    = t_ready_kind'($urandom_range(0, 3));
            run_len = $urandom_range(8, 48);
            if (hold_now) begin
                hold_now = 1'b0;
                kind     = RDY_HOLD;
                run_len  = HOLD_CYCLES;
            end
            repeat (run_len) begin
                @(negedge i_clk);
                case (kind)
                    RDY_STEADY: i_ready <= 1'b1;
                    RDY_COIN:   i_ready <= ($urandom_range(0, 1) == 1);
                    RDY_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    RDY_MOSTLY: i_ready <= ($urandom_range(0, 5) != 0);
                    default:    i_ready <= 1'b0;
                endcase
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule
